// ----- src/int_matrix_multiply_accumulate_assert.svh -----
// Assertion macros for the matrix multiply-accumulate checker.
// No dependencies; included by the checker file.
`ifndef INT_MATRIX_MULTIPLY_ACCUMULATE_ASSERT_SVH
`define INT_MATRIX_MULTIPLY_ACCUMULATE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IMMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("imma assertion failed");

// Next-cycle implication, disabled during reset.
`define IMMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("imma assertion failed");

`endif

// ----- src/imma_pkg.sv -----
// Shared constants, codes and types of the matrix multiply-accumulate block.
// No dependencies.
package imma_pkg;

	localparam int IDX_W  = 6;
	localparam int MAX_N  = 1 << IDX_W;
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = MAX_N * MAX_N;
	localparam int DATA_W = 32;
	localparam int SIZE_W = 7;
	localparam int OP_W   = 3;

	localparam logic [OP_W-1:0] OP_LOAD_A = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD_C = 3'd2;
	localparam logic [OP_W-1:0] OP_COMPUTE = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_C = 3'd4;

	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_N);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_WB,
		ST_RDC
	} st_t;

	typedef struct packed {
		logic              idle;
		logic              mul_en;
		logic              c_wr;
		logic              done;
		logic              rdc;
		logic [ADDR_W-1:0] a_addr;
		logic [ADDR_W-1:0] b_addr;
		logic [ADDR_W-1:0] c_addr;
	} seq_ctl_t;

endpackage

// ----- src/int_matrix_multiply_accumulate.sv -----
// Square signed 32-bit matrix multiply-accumulate, C += A*B, top level.
// Input items carry op, row, col and value; op loads one element of A, B or C,
// starts a compute, or reads one element of C. Both channels use valid/stall.
// cfg_we writes cfg_wdata into matrix_size (1..64, larger values act as 64,
// zero makes a compute a no-op); write it only while the block is idle.
// A load gives no result. A read gives a read item after the RAM read register and
// the output register. A compute runs all N^3 multiply-adds, one at a time on the shared
// unit (RAM read, registered multiply, add and write back), and then gives one done item;
// with size zero the done item comes at once.
// Input stall is high while a compute or read is in flight, and while a result
// sits in the output register with out_stall high; a stalled result holds.
// Reset clears the sequencer, the output valid and sets matrix_size to 64; the
// three 4096-entry stores are not cleared and must be loaded before use.
// Results are registered; sums and products wrap modulo 2^32.
// Depends on imma_pkg, imma_ram, imma_mac, imma_seq.
module int_matrix_multiply_accumulate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [imma_pkg::SIZE_W-1:0]       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [imma_pkg::OP_W-1:0]         op,
	input  logic [imma_pkg::IDX_W-1:0]        row,
	input  logic [imma_pkg::IDX_W-1:0]        col,
	input  logic signed [imma_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              result_kind,
	output logic signed [imma_pkg::DATA_W-1:0] result_value
);

	logic [imma_pkg::SIZE_W-1:0] size_q;
	logic [imma_pkg::SIZE_W-1:0] n_eff;
	logic [imma_pkg::IDX_W-1:0]  last_idx;
	logic                        size_zero;

	logic in_acc, start, read_go, done_now;
	logic we_a, we_b, we_c;
	logic [imma_pkg::ADDR_W-1:0] in_addr, c_waddr;
	logic [imma_pkg::DATA_W-1:0] c_wdata, rd_a, rd_b, rd_c, mac_sum;

	logic                        out_valid_q;
	logic                        kind_q;
	logic [imma_pkg::DATA_W-1:0] value_q;

	imma_pkg::seq_ctl_t ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= imma_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	assign n_eff     = (size_q > imma_pkg::SIZE_RESET) ? imma_pkg::SIZE_RESET : size_q;
	assign last_idx  = imma_pkg::IDX_W'(n_eff - 1'b1);
	assign size_zero = (size_q == '0);

	assign in_stall = !ctl.idle || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign in_addr  = {row, col};

	assign start    = in_acc && (op == imma_pkg::OP_COMPUTE) && !size_zero;
	assign done_now = in_acc && (op == imma_pkg::OP_COMPUTE) && size_zero;
	assign read_go  = in_acc && (op == imma_pkg::OP_READ_C);

	assign we_a = in_acc && (op == imma_pkg::OP_LOAD_A);
	assign we_b = in_acc && (op == imma_pkg::OP_LOAD_B);
	assign we_c = (in_acc && (op == imma_pkg::OP_LOAD_C)) || ctl.c_wr;

	assign c_waddr = ctl.c_wr ? ctl.c_addr : in_addr;
	assign c_wdata = ctl.c_wr ? mac_sum : value;

	imma_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.read_go  (read_go),
		.last_idx (last_idx),
		.row      (row),
		.col      (col),
		.ctl      (ctl)
	);

	imma_ram #(.WIDTH(imma_pkg::DATA_W), .DEPTH(imma_pkg::DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (in_addr),
		.wdata (value),
		.raddr (ctl.a_addr),
		.rdata (rd_a)
	);

	imma_ram #(.WIDTH(imma_pkg::DATA_W), .DEPTH(imma_pkg::DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (in_addr),
		.wdata (value),
		.raddr (ctl.b_addr),
		.rdata (rd_b)
	);

	imma_ram #(.WIDTH(imma_pkg::DATA_W), .DEPTH(imma_pkg::DEPTH)) u_ram_c (
		.clk   (clk),
		.we    (we_c),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (ctl.c_addr),
		.rdata (rd_c)
	);

	imma_mac u_mac (
		.clk    (clk),
		.mul_en (ctl.mul_en),
		.a      (rd_a),
		.b      (rd_b),
		.c      (rd_c),
		.sum    (mac_sum)
	);

	// output register; new items only land once the previous one is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_now || ctl.done || ctl.rdc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rdc) begin
			kind_q  <= imma_pkg::KIND_READ;
			value_q <= rd_c;
		end else if (done_now || ctl.done) begin
			kind_q  <= imma_pkg::KIND_DONE;
			value_q <= '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign result_value = value_q;

endmodule

// ----- src/imma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/imma_mac.sv -----
// Shared multiply-add unit: registered 32-bit wrapping product, then add to C.
// Depends on imma_pkg.
module imma_mac (
	input  logic                       clk,
	input  logic                       mul_en,
	input  logic [imma_pkg::DATA_W-1:0] a,
	input  logic [imma_pkg::DATA_W-1:0] b,
	input  logic [imma_pkg::DATA_W-1:0] c,
	output logic [imma_pkg::DATA_W-1:0] sum
);

	logic [imma_pkg::DATA_W-1:0] prod_s1;

	// low word of the product is the same for signed and unsigned operands
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= a * b;
		end
	end

	assign sum = c + prod_s1;

endmodule

// ----- src/imma_seq.sv -----
// Sequencer: walks i, k, j over the active size, one multiply-add at a time through the
// read, multiply and write-back states, and handles the read-back step. Depends on imma_pkg.
module imma_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       read_go,
	input  logic [imma_pkg::IDX_W-1:0] last_idx,
	input  logic [imma_pkg::IDX_W-1:0] row,
	input  logic [imma_pkg::IDX_W-1:0] col,
	output imma_pkg::seq_ctl_t         ctl
);

	imma_pkg::st_t state_q, state_d;
	logic [imma_pkg::IDX_W-1:0] i_q, k_q, j_q;
	logic j_last, k_last, i_last, all_last;

	assign j_last   = (j_q == last_idx);
	assign k_last   = (k_q == last_idx);
	assign i_last   = (i_q == last_idx);
	assign all_last = j_last && k_last && i_last;

	always_comb begin
		state_d = state_q;
		case (state_q)
			imma_pkg::ST_IDLE: begin
				if (start) begin
					state_d = imma_pkg::ST_READ;
				end else if (read_go) begin
					state_d = imma_pkg::ST_RDC;
				end
			end
			imma_pkg::ST_READ: state_d = imma_pkg::ST_MUL;
			imma_pkg::ST_MUL:  state_d = imma_pkg::ST_WB;
			imma_pkg::ST_WB: begin
				state_d = all_last ? imma_pkg::ST_IDLE : imma_pkg::ST_READ;
			end
			imma_pkg::ST_RDC:  state_d = imma_pkg::ST_IDLE;
			default:           state_d = imma_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imma_pkg::ST_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == imma_pkg::ST_IDLE && start) begin
				i_q <= '0;
				k_q <= '0;
				j_q <= '0;
			end else if (state_q == imma_pkg::ST_WB) begin
				// advance j fastest, then k, then i
				if (!j_last) begin
					j_q <= j_q + 1'b1;
				end else begin
					j_q <= '0;
					if (!k_last) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						i_q <= i_q + 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		ctl.idle   = (state_q == imma_pkg::ST_IDLE);
		ctl.mul_en = (state_q == imma_pkg::ST_MUL);
		ctl.c_wr   = (state_q == imma_pkg::ST_WB);
		ctl.done   = (state_q == imma_pkg::ST_WB) && all_last;
		ctl.rdc    = (state_q == imma_pkg::ST_RDC);
		ctl.a_addr = {i_q, k_q};
		ctl.b_addr = {k_q, j_q};
		ctl.c_addr = (state_q == imma_pkg::ST_IDLE) ? {row, col} : {i_q, j_q};
	end

endmodule

// ----- src/imma_chk.sv -----
// Port-level checker for the matrix multiply-accumulate block, with its bind.
// Depends on imma_pkg and int_matrix_multiply_accumulate_assert.svh.
`include "int_matrix_multiply_accumulate_assert.svh"

module imma_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [imma_pkg::OP_W-1:0]         op,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              result_kind,
	input logic signed [imma_pkg::DATA_W-1:0] result_value
);

	logic in_acc, load_acc, read_acc;

	assign in_acc   = in_valid && !in_stall;
	assign load_acc = in_acc && (op == imma_pkg::OP_LOAD_A || op == imma_pkg::OP_LOAD_B ||
		op == imma_pkg::OP_LOAD_C);
	assign read_acc = in_acc && (op == imma_pkg::OP_READ_C);

	// a waiting result holds
	`IMMA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_kind) && $stable(result_value))
	// no new item enters while a result is blocked
	`IMMA_ASSERT_IMPL(a_in_blocked, clk, arst_n, out_valid && out_stall, in_stall)
	// a read returns a read item after the RAM read and output registers
	`IMMA_ASSERT_IMPL(a_read_lat, clk, arst_n, read_acc, ##2 (out_valid && result_kind == imma_pkg::KIND_READ))
	// done items carry zero
	`IMMA_ASSERT_IMPL(a_done_zero, clk, arst_n, out_valid && result_kind == imma_pkg::KIND_DONE, result_value == '0)
	// a load leaves the block idle
	`IMMA_ASSERT_NEXT(a_load_one, clk, arst_n, load_acc, in_stall == (out_valid && out_stall))

endmodule

bind int_matrix_multiply_accumulate imma_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.op           (op),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_kind  (result_kind),
	.result_value (result_value)
);
